>>> sv/gbd_pkg.sv
package gbd_pkg;

    localparam int GRID_SIDE_DEF = 32;
    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] GRID_SIZE_RST = 6'd32;
    localparam logic [9:0] DIST_MAX = 10'd1023;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_DIST  = 2'd1;
    localparam logic [1:0] REQ_NEAR  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // neighbour order: up, right, down, left
    localparam logic signed [1:0] ROW_STEP [4] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};
    localparam logic signed [1:0] COL_STEP [4] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] row;
        logic [4:0] col;
        logic       is_wall;
        logic       is_target;
        logic [4:0] dst_row;
        logic [4:0] dst_col;
    } t_req;

    typedef struct packed {
        logic       reachable;
        logic [9:0] distance;
        logic [4:0] found_row;
        logic [4:0] found_col;
    } t_rsp;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_sts;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WR,
        ST_SRC_RD,
        ST_SRC_CHK,
        ST_INIT,
        ST_POP,
        ST_Q_RD,
        ST_NBR_RD,
        ST_NBR_CHK,
        ST_DONE
    } t_eng_state;

endpackage

>>> sv/gbd_engine.sv
module gbd_engine #(
    parameter int GRID_SIDE = gbd_pkg::GRID_SIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  gbd_pkg::t_req            i_req,
    input  logic [gbd_pkg::CFG_W-1:0] i_grid_size,
    input  logic                     i_take,
    output gbd_pkg::t_eng_sts        o_sts,
    output gbd_pkg::t_rsp            o_rsp
);

    localparam int CW  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int NW  = $clog2(GRID_SIDE + 1);
    localparam int XW  = ((NW > 5) ? NW : 5) + 1;
    localparam int QD  = GRID_SIDE * GRID_SIDE;
    localparam int QW  = $clog2(QD + 1);
    localparam int QAW = $clog2(QD);

    gbd_pkg::t_eng_state r_state, n_state;
    gbd_pkg::t_req       r_req;
    gbd_pkg::t_rsp       r_rsp;

    logic [GRID_SIDE-1:0] r_wall_mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] r_tgt_mem  [GRID_SIDE];
    logic [GRID_SIDE-1:0] r_vis_mem  [GRID_SIDE];
    logic [2*CW-1:0]      r_q_mem    [QD];

    logic [GRID_SIDE-1:0] r_wall_q, r_tgt_q, r_vis_q;
    logic                 r_wt_vq, r_vis_vq;
    logic [2*CW-1:0]      r_q_q;
    logic [GRID_SIDE-1:0] r_wt_vld, r_vis_vld;

    logic [CW-1:0] r_cr, r_cc, r_nr, r_nc, r_fr, r_fc;
    logic [1:0]    r_k;
    logic [QW-1:0] r_head, r_tail, r_lvl_end, r_level;
    logic          r_got;

    logic [NW-1:0]        n_size;
    logic                 in_src_ok, in_store_ok, in_same;
    logic [GRID_SIDE-1:0] wall_row, tgt_row, vis_row, nc_bit, wc_bit, src_bit;
    logic signed [XW-1:0] nr_x, nc_x, n_sx;
    logic                 nbr_ok, blocked, hit_dst, is_tgt, better, last_k, src_live, push;
    logic [QW-1:0]        lvl1;
    logic [9:0]           dist_sat;

    logic [CW-1:0]        row_addr;
    logic                 wt_we, vis_we, q_we;
    logic [GRID_SIDE-1:0] wall_wd, tgt_wd, vis_wd;
    logic [CW-1:0]        vis_waddr;
    logic [QAW-1:0]       q_waddr;
    logic [2*CW-1:0]      q_wd;

    always_comb begin
        if (i_grid_size == '0) begin
            n_size = NW'(1);
        end else if (XW'(i_grid_size) > XW'(GRID_SIDE)) begin
            n_size = NW'(GRID_SIDE);
        end else begin
            n_size = NW'(i_grid_size);
        end
    end

    assign in_src_ok   = (XW'(i_req.row) < XW'(n_size)) && (XW'(i_req.col) < XW'(n_size));
    assign in_store_ok = (XW'(i_req.row) < XW'(GRID_SIDE)) && (XW'(i_req.col) < XW'(GRID_SIDE));
    assign in_same     = (i_req.row == i_req.dst_row) && (i_req.col == i_req.dst_col);

    assign wall_row = r_wt_vq  ? r_wall_q : '0;
    assign tgt_row  = r_wt_vq  ? r_tgt_q  : '0;
    assign vis_row  = r_vis_vq ? r_vis_q  : '0;
    assign nc_bit   = GRID_SIDE'(1) << r_nc;
    assign wc_bit   = GRID_SIDE'(1) << CW'(r_req.col);
    assign src_bit  = wc_bit;

    assign n_sx   = signed'(XW'(n_size));
    assign nr_x   = signed'(XW'(r_cr)) + XW'(gbd_pkg::ROW_STEP[r_k]);
    assign nc_x   = signed'(XW'(r_cc)) + XW'(gbd_pkg::COL_STEP[r_k]);
    assign nbr_ok = (nr_x >= 0) && (nc_x >= 0) && (nr_x < n_sx) && (nc_x < n_sx);
    assign last_k = (r_k == 2'd3);

    assign blocked  = wall_row[r_nc] | vis_row[r_nc];
    assign hit_dst  = (r_req.req_type == gbd_pkg::REQ_DIST)
                      && (XW'(r_nr) == XW'(r_req.dst_row))
                      && (XW'(r_nc) == XW'(r_req.dst_col));
    assign is_tgt   = (r_req.req_type == gbd_pkg::REQ_NEAR) && tgt_row[r_nc];
    assign better   = !r_got || (r_nr < r_fr) || ((r_nr == r_fr) && (r_nc < r_fc));
    assign src_live = tgt_row[CW'(r_req.col)] && !wall_row[CW'(r_req.col)];
    assign push     = (r_state == gbd_pkg::ST_NBR_CHK) && !blocked && !hit_dst && !is_tgt
                      && (r_tail < QW'(QD));

    assign lvl1     = r_level + QW'(1);
    assign dist_sat = (32'(lvl1) > 32'(gbd_pkg::DIST_MAX)) ? gbd_pkg::DIST_MAX : 10'(lvl1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbd_pkg::ST_IDLE: begin
                if (i_start) begin
                    unique case (i_req.req_type)
                        gbd_pkg::REQ_WRITE: n_state = in_store_ok ? gbd_pkg::ST_WR_RD
                                                                  : gbd_pkg::ST_IDLE;
                        gbd_pkg::REQ_DIST:  n_state = (!in_src_ok || in_same) ? gbd_pkg::ST_DONE
                                                                              : gbd_pkg::ST_INIT;
                        gbd_pkg::REQ_NEAR:  n_state = !in_src_ok ? gbd_pkg::ST_DONE
                                                                 : gbd_pkg::ST_SRC_RD;
                        gbd_pkg::REQ_NONE:  n_state = gbd_pkg::ST_IDLE;
                    endcase
                end
            end
            gbd_pkg::ST_WR_RD:   n_state = gbd_pkg::ST_WR_WR;
            gbd_pkg::ST_WR_WR:   n_state = gbd_pkg::ST_IDLE;
            gbd_pkg::ST_SRC_RD:  n_state = gbd_pkg::ST_SRC_CHK;
            gbd_pkg::ST_SRC_CHK: n_state = src_live ? gbd_pkg::ST_DONE : gbd_pkg::ST_INIT;
            gbd_pkg::ST_INIT:    n_state = gbd_pkg::ST_POP;
            gbd_pkg::ST_POP: begin
                priority if (r_head == r_lvl_end) begin
                    if (r_got || (r_head == r_tail)) begin
                        n_state = gbd_pkg::ST_DONE;
                    end
                end else begin
                    n_state = gbd_pkg::ST_Q_RD;
                end
            end
            gbd_pkg::ST_Q_RD: n_state = gbd_pkg::ST_NBR_RD;
            gbd_pkg::ST_NBR_RD: begin
                priority if (nbr_ok) begin
                    n_state = gbd_pkg::ST_NBR_CHK;
                end else if (last_k) begin
                    n_state = gbd_pkg::ST_POP;
                end
            end
            gbd_pkg::ST_NBR_CHK: begin
                priority if (!blocked && hit_dst) begin
                    n_state = gbd_pkg::ST_DONE;
                end else if (last_k) begin
                    n_state = gbd_pkg::ST_POP;
                end else begin
                    n_state = gbd_pkg::ST_NBR_RD;
                end
            end
            gbd_pkg::ST_DONE: begin
                if (i_take) begin
                    n_state = gbd_pkg::ST_IDLE;
                end
            end
            default: n_state = gbd_pkg::ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        row_addr  = CW'(r_req.row);
        wt_we     = 1'b0;
        wall_wd   = (wall_row & ~wc_bit) | (r_req.is_wall ? wc_bit : '0);
        tgt_wd    = (tgt_row & ~wc_bit) | (r_req.is_target ? wc_bit : '0);
        vis_we    = 1'b0;
        vis_waddr = r_nr;
        vis_wd    = vis_row | nc_bit;
        q_we      = push;
        q_waddr   = r_tail[QAW-1:0];
        q_wd      = {r_nr, r_nc};
        unique case (r_state)
            gbd_pkg::ST_WR_WR: wt_we = 1'b1;
            gbd_pkg::ST_INIT: begin
                vis_we    = 1'b1;
                vis_waddr = CW'(r_req.row);
                vis_wd    = src_bit;
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wd      = {CW'(r_req.row), CW'(r_req.col)};
            end
            gbd_pkg::ST_NBR_RD:  row_addr = CW'(nr_x);
            gbd_pkg::ST_NBR_CHK: vis_we = !blocked && !hit_dst;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wall_q <= r_wall_mem[row_addr];
        r_tgt_q  <= r_tgt_mem[row_addr];
        r_vis_q  <= r_vis_mem[row_addr];
        r_q_q    <= r_q_mem[r_head[QAW-1:0]];
        if (wt_we) begin
            r_wall_mem[CW'(r_req.row)] <= wall_wd;
            r_tgt_mem[CW'(r_req.row)]  <= tgt_wd;
        end
        if (vis_we) begin
            r_vis_mem[vis_waddr] <= vis_wd;
        end
        if (q_we) begin
            r_q_mem[q_waddr] <= q_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= gbd_pkg::ST_IDLE;
            r_wt_vld  <= '0;
            r_vis_vld <= '0;
            r_wt_vq   <= 1'b0;
            r_vis_vq  <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_lvl_end <= '0;
            r_level   <= '0;
            r_got     <= 1'b0;
            r_k       <= '0;
        end else begin
            r_state  <= n_state;
            r_wt_vq  <= r_wt_vld[row_addr];
            r_vis_vq <= r_vis_vld[row_addr];
            if (wt_we) begin
                r_wt_vld[CW'(r_req.row)] <= 1'b1;
            end
            unique case (r_state)
                gbd_pkg::ST_INIT: begin
                    r_vis_vld <= GRID_SIDE'(1) << CW'(r_req.row);
                    r_head    <= '0;
                    r_tail    <= QW'(1);
                    r_lvl_end <= QW'(1);
                    r_level   <= '0;
                    r_got     <= 1'b0;
                end
                gbd_pkg::ST_POP: begin
                    if (r_head == r_lvl_end) begin
                        if (!r_got && (r_head != r_tail)) begin
                            r_lvl_end <= r_tail;
                            r_level   <= lvl1;
                        end
                    end else begin
                        r_head <= r_head + QW'(1);
                    end
                end
                gbd_pkg::ST_Q_RD: r_k <= '0;
                gbd_pkg::ST_NBR_RD: begin
                    if (!nbr_ok) begin
                        r_k <= r_k + 2'd1;
                    end
                end
                gbd_pkg::ST_NBR_CHK: begin
                    r_k <= r_k + 2'd1;
                    if (!blocked && !hit_dst) begin
                        r_vis_vld[r_nr] <= 1'b1;
                        if (is_tgt) begin
                            r_got <= 1'b1;
                        end
                        if (push) begin
                            r_tail <= r_tail + QW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            gbd_pkg::ST_IDLE: begin
                r_req               <= i_req;
                r_rsp.reachable     <= (i_req.req_type == gbd_pkg::REQ_DIST) && in_src_ok
                                       && in_same;
                r_rsp.distance      <= '0;
                r_rsp.found_row     <= (i_req.req_type == gbd_pkg::REQ_DIST) ? i_req.dst_row
                                                                             : 5'd0;
                r_rsp.found_col     <= (i_req.req_type == gbd_pkg::REQ_DIST) ? i_req.dst_col
                                                                             : 5'd0;
            end
            gbd_pkg::ST_SRC_CHK: begin
                if (src_live) begin
                    r_rsp.reachable <= 1'b1;
                    r_rsp.found_row <= r_req.row;
                    r_rsp.found_col <= r_req.col;
                end
            end
            gbd_pkg::ST_POP: begin
                if ((r_head == r_lvl_end) && r_got) begin
                    r_rsp.reachable <= 1'b1;
                    r_rsp.distance  <= dist_sat;
                    r_rsp.found_row <= 5'(r_fr);
                    r_rsp.found_col <= 5'(r_fc);
                end
            end
            gbd_pkg::ST_Q_RD: begin
                r_cr <= r_q_q[2*CW-1:CW];
                r_cc <= r_q_q[CW-1:0];
            end
            gbd_pkg::ST_NBR_RD: begin
                r_nr <= CW'(nr_x);
                r_nc <= CW'(nc_x);
            end
            gbd_pkg::ST_NBR_CHK: begin
                if (!blocked && hit_dst) begin
                    r_rsp.reachable <= 1'b1;
                    r_rsp.distance  <= dist_sat;
                end
                if (!blocked && !hit_dst && is_tgt && better) begin
                    r_fr <= r_nr;
                    r_fc <= r_nc;
                end
            end
            default: ;
        endcase
    end

    assign o_sts.idle = (r_state == gbd_pkg::ST_IDLE);
    assign o_sts.done = (r_state == gbd_pkg::ST_DONE);
    assign o_rsp      = r_rsp;

    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= QW'(QD))
        else $error("queue overfilled");

    a_chk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbd_pkg::ST_NBR_CHK) |-> ($past(r_state) == gbd_pkg::ST_NBR_RD))
        else $error("neighbour check without read");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbd_pkg::ST_DONE && !r_rsp.reachable) |-> (r_rsp.distance == '0))
        else $error("unreached result with distance");

endmodule

>>> sv/grid_bfs_distance_and_nearest.sv
// grid breadth-first search: shortest distance and nearest target
// input channel: i_in_valid / o_in_ready carry one request word (t_req)
//   write: sets the wall and target marks of one cell, no result word
//   distance query: search from (row, col) to (dst_row, dst_col)
//   nearest query: search from (row, col) for the closest target cell
// output channel: o_out_valid / i_out_ready carry one result word (t_rsp)
// config: i_cfg_we / i_cfg_wdata write the grid side length, only while idle;
//   the user is bound to this, the block itself leaves it unchecked
// a query with source outside the grid or a trivial hit ends without a
//   search; a full search takes each dequeued cell through pop, queue
//   read and, for each of its four neighbours, a read plus a check if in
//   the grid, plus one pop per level; the single neighbour check unit
//   paces it, reading one row of wall, target and visited store per access
// one request is in work at a time; o_in_ready is high when the engine is idle
// a finished result sits in the output register while the next request runs
// a stalled receiver holds o_out_valid and the word; the engine then waits
//   with its result until the output register frees
// reset clears all marks, the grid side to 32 and both channels
module grid_bfs_distance_and_nearest #(
    parameter int GRID_SIDE = gbd_pkg::GRID_SIDE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  gbd_pkg::t_req             i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output gbd_pkg::t_rsp             o_out_data,
    input  logic                      i_cfg_we,
    input  logic [gbd_pkg::CFG_W-1:0] i_cfg_wdata
);

    logic [gbd_pkg::CFG_W-1:0] r_grid_size;
    logic                      r_out_vld;
    gbd_pkg::t_rsp             r_out;
    gbd_pkg::t_eng_sts         eng_sts;
    gbd_pkg::t_rsp             eng_rsp;
    logic                      slot_free, take, start;

    assign slot_free = !r_out_vld || i_out_ready;
    assign take      = eng_sts.done && slot_free;
    assign start     = i_in_valid && eng_sts.idle;

    gbd_engine #(
        .GRID_SIDE (GRID_SIDE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_in_data),
        .i_grid_size (r_grid_size),
        .i_take      (take),
        .o_sts       (eng_sts),
        .o_rsp       (eng_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= gbd_pkg::GRID_SIZE_RST;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_grid_size <= i_cfg_wdata;
            end
            if (take) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= eng_rsp;
        end
    end

    assign o_in_ready  = eng_sts.idle;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
